### rtl/hpts_pkg.sv
// Shared types, constants and helpers for the prism/hexahedron tetra split.
// Used by hpts_front, hpts_split and the top level.
`default_nettype none
package hpts_pkg;
  localparam int VERTEX_BITS = 32;
  localparam int CODE_BITS   = 8;
  localparam int TET_MAX     = 6;

  typedef logic [VERTEX_BITS-1:0] vid_t;
  typedef logic [CODE_BITS-1:0]   code_t;
  typedef logic [2:0]             lidx_t;
  typedef logic [2:0]             tcnt_t;

  // All-ones code marks an interior face
  localparam code_t INTERIOR = '1;

  typedef enum logic [1:0] {
    MODE_PRISM     = 2'd0,
    MODE_TWO_PRISM = 2'd1,
    MODE_HEX5      = 2'd2
  } mode_t;

  typedef struct packed {
    vid_t  [5:0] v;
    code_t [4:0] c;
  } prism_t;

  typedef struct packed {
    vid_t  [3:0] v;
    code_t [3:0] c;
  } tet_t;

  typedef struct packed {
    mode_t         mode;
    prism_t  [1:0] pr;
    tet_t    [4:0] hx;
  } elem_t;

  function automatic tet_t mk_tet(input vid_t p, input vid_t q, input vid_t r,
                                  input vid_t s, input code_t c0, input code_t c1,
                                  input code_t c2, input code_t c3);
    tet_t t;
    t.v[0] = p; t.v[1] = q; t.v[2] = r; t.v[3] = s;
    t.c[0] = c0; t.c[1] = c1; t.c[2] = c2; t.c[3] = c3;
    return t;
  endfunction

  function automatic vid_t min2(input vid_t x, input vid_t y);
    return (x < y) ? x : y;
  endfunction

  // Min index over six ids, ties to the lowest index (pairwise tree)
  function automatic lidx_t min6(input vid_t [5:0] v);
    lidx_t i01, i23, i45, i03;
    i01 = (v[1] < v[0]) ? 3'd1 : 3'd0;
    i23 = (v[3] < v[2]) ? 3'd3 : 3'd2;
    i45 = (v[5] < v[4]) ? 3'd5 : 3'd4;
    i03 = (v[i23] < v[i01]) ? i23 : i01;
    return (v[i45] < v[i03]) ? i45 : i03;
  endfunction

  // Min index over eight ids, ties to the lowest index
  function automatic lidx_t min8(input vid_t [7:0] v);
    lidx_t i01, i23, i45, i67, i03, i47;
    i01 = (v[1] < v[0]) ? 3'd1 : 3'd0;
    i23 = (v[3] < v[2]) ? 3'd3 : 3'd2;
    i45 = (v[5] < v[4]) ? 3'd5 : 3'd4;
    i67 = (v[7] < v[6]) ? 3'd7 : 3'd6;
    i03 = (v[i23] < v[i01]) ? i23 : i01;
    i47 = (v[i67] < v[i45]) ? i67 : i45;
    return (v[i47] < v[i03]) ? i47 : i03;
  endfunction
endpackage
`default_nettype wire

### rtl/hpts_front.sv
// Front stages: input register, min-vertex search, rotation and pair tests.
// Depends on hpts_pkg; hands one element descriptor per transfer.
`default_nettype none
module hpts_front import hpts_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_func,
  input  wire vid_t  [7:0] in_vert,
  input  wire code_t [5:0] in_codes,
  output logic             el_valid,
  input  wire logic        el_ready,
  output elem_t            el_data
);
  logic        a_v_r, b_v_r, c_v_r;
  logic        a_rdy, b_rdy, c_rdy;
  logic        a_func_r, b_func_r;
  vid_t  [7:0] a_vert_r, b_vert_r;
  code_t [5:0] a_code_r, b_code_r;
  lidx_t       b_m_r;
  elem_t       c_e_r, c_e_nxt;

  assign c_rdy    = !c_v_r || el_ready;
  assign b_rdy    = !b_v_r || c_rdy;
  assign a_rdy    = !a_v_r || b_rdy;
  assign in_ready = a_rdy;
  assign el_valid = c_v_r;
  assign el_data  = c_e_r;

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else begin
      if (a_rdy) a_v_r <= in_valid;
      if (b_rdy) b_v_r <= a_v_r;
      if (c_rdy) c_v_r <= b_v_r;
    end
  end

  // Stage A: capture the transfer; stage B: find the min vertex
  always_ff @(posedge clk) begin
    if (a_rdy && in_valid) begin
      a_func_r <= in_func;
      a_vert_r <= in_vert;
      a_code_r <= in_codes;
    end
    if (b_rdy && a_v_r) begin
      b_func_r <= a_func_r;
      b_vert_r <= a_vert_r;
      b_code_r <= a_code_r;
      b_m_r    <= a_func_r ? min8(a_vert_r) : min6(a_vert_r[5:0]);
    end
    if (c_rdy && b_v_r) c_e_r <= c_e_nxt;
  end

  function automatic logic pair_hit(input vid_t [7:0] rv, input lidx_t q0,
                                    input lidx_t q1, input lidx_t q2, input lidx_t q3);
    return min2(rv[q0], rv[q2]) < min2(rv[q1], rv[q3]);
  endfunction

  // Two prisms of a face pair with parallel diagonals
  function automatic prism_t [1:0] pair_prisms(input vid_t [7:0] rv,
      input lidx_t p0, input lidx_t p1, input lidx_t p2, input lidx_t p3,
      input lidx_t q0, input lidx_t q1, input lidx_t q2, input lidx_t q3,
      input code_t [5:0] c);
    prism_t [1:0] pr;
    pr[0].v[0] = rv[p0]; pr[0].v[1] = rv[p2]; pr[0].v[2] = rv[p3];
    pr[0].v[3] = rv[q0]; pr[0].v[4] = rv[q2]; pr[0].v[5] = rv[q3];
    pr[0].c[0] = INTERIOR; pr[0].c[1] = c[2]; pr[0].c[2] = c[3];
    pr[0].c[3] = c[4];     pr[0].c[4] = c[5];
    pr[1].v[0] = rv[p0]; pr[1].v[1] = rv[p1]; pr[1].v[2] = rv[p2];
    pr[1].v[3] = rv[q0]; pr[1].v[4] = rv[q1]; pr[1].v[5] = rv[q2];
    pr[1].c[0] = c[0]; pr[1].c[1] = c[1]; pr[1].c[2] = INTERIOR;
    pr[1].c[3] = c[4]; pr[1].c[4] = c[5];
    return pr;
  endfunction

  // Stage C: rotate the hexahedron and choose the split
  always_comb begin
    vid_t  [7:0] rv;
    code_t [5:0] f, c2, c3;
    lidx_t       aix [8];
    logic  [1:0] low;
    logic        t1, t2, t3;
    for (int k = 0; k < 4; k++) begin
      low        = b_m_r[1:0] + 2'(k);
      aix[k]     = {b_m_r[2], low};
      aix[k + 4] = {~b_m_r[2], low};
      f[k]       = b_code_r[{1'b0, low}];
    end
    f[4] = b_m_r[2] ? b_code_r[5] : b_code_r[4];
    f[5] = b_m_r[2] ? b_code_r[4] : b_code_r[5];
    for (int k = 0; k < 8; k++) rv[k] = b_vert_r[aix[k]];
    c2[0] = f[4]; c2[1] = f[1]; c2[2] = f[5]; c2[3] = f[3]; c2[4] = f[0]; c2[5] = f[2];
    c3[0] = f[0]; c3[1] = f[5]; c3[2] = f[2]; c3[3] = f[4]; c3[4] = f[3]; c3[5] = f[1];
    t1 = pair_hit(rv, 3'd4, 3'd5, 3'd6, 3'd7);
    t2 = pair_hit(rv, 3'd3, 3'd2, 3'd6, 3'd7);
    t3 = pair_hit(rv, 3'd1, 3'd5, 3'd6, 3'd2);

    c_e_nxt.hx[0] = mk_tet(rv[0], rv[4], rv[5], rv[7], f[5], INTERIOR, f[3], f[0]);
    c_e_nxt.hx[1] = mk_tet(rv[0], rv[2], rv[3], rv[7], f[2], f[3], INTERIOR, f[4]);
    c_e_nxt.hx[2] = mk_tet(rv[0], rv[1], rv[2], rv[5], f[1], INTERIOR, f[0], f[4]);
    c_e_nxt.hx[3] = mk_tet(rv[2], rv[5], rv[6], rv[7], f[5], f[2], INTERIOR, f[1]);
    c_e_nxt.hx[4] = mk_tet(rv[0], rv[2], rv[5], rv[7],
                           INTERIOR, INTERIOR, INTERIOR, INTERIOR);

    if (!b_func_r) begin
      c_e_nxt.mode    = MODE_PRISM;
      c_e_nxt.pr[0].v = b_vert_r[5:0];
      c_e_nxt.pr[0].c = b_code_r[4:0];
      c_e_nxt.pr[1]   = c_e_nxt.pr[0];
    end else if (t1) begin
      c_e_nxt.mode = MODE_TWO_PRISM;
      c_e_nxt.pr   = pair_prisms(rv, 3'd0, 3'd1, 3'd2, 3'd3,
                                 3'd4, 3'd5, 3'd6, 3'd7, f);
    end else if (t2) begin
      c_e_nxt.mode = MODE_TWO_PRISM;
      c_e_nxt.pr   = pair_prisms(rv, 3'd0, 3'd1, 3'd5, 3'd4,
                                 3'd3, 3'd2, 3'd6, 3'd7, c2);
    end else if (t3) begin
      c_e_nxt.mode = MODE_TWO_PRISM;
      c_e_nxt.pr   = pair_prisms(rv, 3'd0, 3'd4, 3'd7, 3'd3,
                                 3'd1, 3'd5, 3'd6, 3'd2, c3);
    end else begin
      c_e_nxt.mode = MODE_HEX5;
      c_e_nxt.pr   = pair_prisms(rv, 3'd0, 3'd1, 3'd2, 3'd3,
                                 3'd4, 3'd5, 3'd6, 3'd7, f);
    end
  end
endmodule
`default_nettype wire

### rtl/hpts_split.sv
// Back stages: prism min search, prism split and the result buffer that
// drains one tetrahedron per transfer. Depends on hpts_pkg.
`default_nettype none
module hpts_split import hpts_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  el_valid,
  output logic       el_ready,
  input  wire elem_t el_data,
  output logic       tet_valid,
  input  wire logic  tet_ready,
  output tet_t       tet_data,
  output logic       tet_last
);
  logic              d_v_r, e_v_r;
  logic              d_rdy, e_free;
  elem_t             d_e_r;
  lidx_t             d_m0_r, d_m1_r;
  tet_t  [TET_MAX-1:0] buf_r, buf_nxt;
  tcnt_t             cnt_r, cnt_nxt, idx_r;
  tet_t  [2:0]       s0, s1;

  // Three tetrahedra of one prism, given its min-vertex index
  function automatic tet_t [2:0] split3(input prism_t p, input lidx_t m);
    lidx_t       r1, r2, r3, r4, r5, mm, s;
    code_t [4:0] f;
    vid_t        lo1, lo2;
    tet_t  [2:0] t;
    if (m >= 3'd3) begin
      r1 = (m == 3'd5) ? 3'd3 : m + 3'd1;
      r2 = (r1 == 3'd5) ? 3'd3 : r1 + 3'd1;
      r3 = m - 3'd3; r4 = r1 - 3'd3; r5 = r2 - 3'd3;
      mm = m - 3'd3;
    end else begin
      r1 = (m == 3'd2) ? 3'd0 : m + 3'd1;
      r2 = (r1 == 3'd2) ? 3'd0 : r1 + 3'd1;
      r3 = m + 3'd3; r4 = r1 + 3'd3; r5 = r2 + 3'd3;
      mm = m;
    end
    for (int k = 0; k < 3; k++) begin
      s    = mm + 3'(k);
      s    = (s >= 3'd3) ? s - 3'd3 : s;
      f[k] = p.c[s];
    end
    f[3] = (m < 3'd3) ? p.c[3] : p.c[4];
    f[4] = (m < 3'd3) ? p.c[4] : p.c[3];
    lo1  = min2(p.v[r1], p.v[r5]);
    lo2  = min2(p.v[r4], p.v[r2]);
    t[0] = mk_tet(p.v[m], p.v[r3], p.v[r4], p.v[r5], f[4], INTERIOR, f[2], f[0]);
    if (lo1 < lo2) begin
      t[1] = mk_tet(p.v[m], p.v[r1], p.v[r4], p.v[r5], f[1], INTERIOR, INTERIOR, f[0]);
      t[2] = mk_tet(p.v[m], p.v[r2], p.v[r5], p.v[r1], f[1], INTERIOR, f[3], f[2]);
    end else begin
      t[1] = mk_tet(p.v[m], p.v[r1], p.v[r4], p.v[r2], f[1], INTERIOR, f[3], f[0]);
      t[2] = mk_tet(p.v[m], p.v[r2], p.v[r5], p.v[r4], f[1], INTERIOR, INTERIOR, f[2]);
    end
    return t;
  endfunction

  assign tet_valid = e_v_r;
  assign tet_data  = buf_r[idx_r];
  assign tet_last  = (idx_r == cnt_r - 3'd1);
  assign e_free    = !e_v_r || (tet_ready && tet_last);
  assign d_rdy     = !d_v_r || e_free;
  assign el_ready  = d_rdy;

  // Build the full list for the element in stage D
  assign s0 = split3(d_e_r.pr[0], d_m0_r);
  assign s1 = split3(d_e_r.pr[1], d_m1_r);

  always_comb begin
    buf_nxt[2:0] = s0;
    buf_nxt[5:3] = s1;
    cnt_nxt      = 3'd3;
    case (d_e_r.mode)
      MODE_PRISM:     cnt_nxt = 3'd3;
      MODE_TWO_PRISM: cnt_nxt = 3'd6;
      MODE_HEX5: begin
        buf_nxt[4:0] = d_e_r.hx;
        cnt_nxt      = 3'd5;
      end
      default:        cnt_nxt = 3'd3;
    endcase
  end

  // Valid bits and drain index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_v_r <= 1'b0;
      e_v_r <= 1'b0;
      idx_r <= '0;
    end else begin
      if (d_rdy) d_v_r <= el_valid;
      if (e_free) begin
        e_v_r <= d_v_r;
        idx_r <= '0;
      end else if (tet_ready) begin
        idx_r <= idx_r + 3'd1;
      end
    end
  end

  // Hold payload; load the buffer when it frees up
  always_ff @(posedge clk) begin
    if (d_rdy && el_valid) begin
      d_e_r  <= el_data;
      d_m0_r <= min6(el_data.pr[0].v);
      d_m1_r <= min6(el_data.pr[1].v);
    end
    if (e_free && d_v_r) begin
      buf_r <= buf_nxt;
      cnt_r <= cnt_nxt;
    end
  end
endmodule
`default_nettype wire

### rtl/hexa_prism_to_tetra_split_unit.sv
// Prism/hexahedron to tetrahedra split, min-vertex rule.
// An input transfer reaches its first result through register stages A to E.
// Throughput: an element leaves as 3, 5 or 6 result transfers, one per cycle
// while out_ready is high; the single result channel sets the rate, and the
// five register stages let later elements proceed meanwhile. Reset (rst_n
// low, synchronous) empties all stages; no other state is kept.
`default_nettype none
module hexa_prism_to_tetra_split_unit import hpts_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic                   in_func,
  input  wire logic [VERTEX_BITS-1:0] in_vert0,
  input  wire logic [VERTEX_BITS-1:0] in_vert1,
  input  wire logic [VERTEX_BITS-1:0] in_vert2,
  input  wire logic [VERTEX_BITS-1:0] in_vert3,
  input  wire logic [VERTEX_BITS-1:0] in_vert4,
  input  wire logic [VERTEX_BITS-1:0] in_vert5,
  input  wire logic [VERTEX_BITS-1:0] in_vert6,
  input  wire logic [VERTEX_BITS-1:0] in_vert7,
  input  wire logic [47:0]            in_face_codes,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [VERTEX_BITS-1:0]      out_tet_vert_a,
  output logic [VERTEX_BITS-1:0]      out_tet_vert_b,
  output logic [VERTEX_BITS-1:0]      out_tet_vert_c,
  output logic [VERTEX_BITS-1:0]      out_tet_vert_d,
  output logic [31:0]                 out_tet_face_codes,
  output logic                        out_last
);
  vid_t  [7:0] vert;
  code_t [5:0] codes;
  logic        el_valid, el_ready;
  elem_t       el_data;
  tet_t        tet;

  assign vert  = {in_vert7, in_vert6, in_vert5, in_vert4,
                  in_vert3, in_vert2, in_vert1, in_vert0};
  assign codes = in_face_codes;

  hpts_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_func  (in_func),
    .in_vert  (vert),
    .in_codes (codes),
    .el_valid (el_valid),
    .el_ready (el_ready),
    .el_data  (el_data)
  );

  hpts_split u_split (
    .clk       (clk),
    .rst_n     (rst_n),
    .el_valid  (el_valid),
    .el_ready  (el_ready),
    .el_data   (el_data),
    .tet_valid (out_valid),
    .tet_ready (out_ready),
    .tet_data  (tet),
    .tet_last  (out_last)
  );

  assign out_tet_vert_a     = tet.v[0];
  assign out_tet_vert_b     = tet.v[1];
  assign out_tet_vert_c     = tet.v[2];
  assign out_tet_vert_d     = tet.v[3];
  assign out_tet_face_codes = tet.c;
endmodule
`default_nettype wire

### sim/hexa_prism_to_tetra_split_unit_tb.sv
// Testbench for hexa_prism_to_tetra_split_unit: random and directed elements,
// predicted tetra splits checked field by field. Depends on hpts_pkg and the RTL.
`timescale 1ns / 1ps
module hexa_prism_to_tetra_split_unit_tb;
  import hpts_pkg::*;

  typedef struct {
    logic        func;
    vid_t        v [8];
    logic [47:0] codes;
  } elem_in_t;

  typedef struct {
    vid_t        a, b, c, d;
    logic [31:0] fc;
    logic        last;
  } tet_out_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_func = 1'b0;
  vid_t in_vert0 = '0, in_vert1 = '0, in_vert2 = '0, in_vert3 = '0;
  vid_t in_vert4 = '0, in_vert5 = '0, in_vert6 = '0, in_vert7 = '0;
  logic [47:0] in_face_codes = '0;
  logic out_ready = 1'b0;
  logic in_ready, out_valid, out_last;
  vid_t out_tet_vert_a, out_tet_vert_b, out_tet_vert_c, out_tet_vert_d;
  logic [31:0] out_tet_face_codes;

  hexa_prism_to_tetra_split_unit uut (.*);

  always #5 clk = ~clk;

  elem_in_t pending_elems [$];
  tet_out_t expected_tets [$];
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  bit       hold_send = 1'b0;
  int       errors = 0;
  int       tets_seen = 0;
  int       elems_sent = 0;
  int       n_prism = 0, n_two_prism = 0, n_hex5 = 0;
  longint   cycle_cnt = 0;
  logic     xfer_in = 1'b0;

  // Work buffer for one element's tetrahedra
  tet_out_t tet_buf [$];

  function automatic logic [31:0] pack_codes(code_t c0, code_t c1, code_t c2, code_t c3);
    return {c3, c2, c1, c0};
  endfunction

  function automatic void add_tet(vid_t p, vid_t q, vid_t r, vid_t s,
                                  code_t c0, code_t c1, code_t c2, code_t c3);
    tet_out_t t;
    t.a = p; t.b = q; t.c = r; t.d = s;
    t.fc = pack_codes(c0, c1, c2, c3);
    t.last = 1'b0;
    tet_buf.push_back(t);
  endfunction

  function automatic vid_t lo_of(vid_t x, vid_t y);
    return (x < y) ? x : y;
  endfunction

  // Rotate prism to its minimum vertex and cut into three tetrahedra
  function automatic void cut_prism(vid_t v [6], code_t b [5]);
    int m, r1, r2, r3, r4, r5;
    code_t f [5];
    vid_t lo1, lo2;
    m = 0;
    for (int k = 1; k < 6; k++) if (v[k] < v[m]) m = k;
    if (m >= 3) begin
      r1 = (m + 1 > 5) ? 3 : m + 1;
      r2 = (r1 + 1 > 5) ? 3 : r1 + 1;
      r3 = m - 3; r4 = r1 - 3; r5 = r2 - 3;
    end else begin
      r1 = (m + 1 > 2) ? 0 : m + 1;
      r2 = (r1 + 1 > 2) ? 0 : r1 + 1;
      r3 = m + 3; r4 = r1 + 3; r5 = r2 + 3;
    end
    for (int k = 0; k < 3; k++) f[k] = b[(m + k) % 3];
    f[3] = (m < 3) ? b[3] : b[4];
    f[4] = (m < 3) ? b[4] : b[3];
    lo1 = lo_of(v[r1], v[r5]);
    lo2 = lo_of(v[r4], v[r2]);
    add_tet(v[m], v[r3], v[r4], v[r5], f[4], INTERIOR, f[2], f[0]);
    if (lo1 < lo2) begin
      add_tet(v[m], v[r1], v[r4], v[r5], f[1], INTERIOR, INTERIOR, f[0]);
      add_tet(v[m], v[r2], v[r5], v[r1], f[1], INTERIOR, f[3], f[2]);
    end else begin
      add_tet(v[m], v[r1], v[r4], v[r2], f[1], INTERIOR, f[3], f[0]);
      add_tet(v[m], v[r2], v[r5], v[r4], f[1], INTERIOR, INTERIOR, f[2]);
    end
  endfunction

  // Cut hexahedron along one face pair when its far diagonals run parallel
  function automatic bit cut_pair(vid_t v [8], int p [4], int q [4], code_t c [6]);
    vid_t pv [6];
    code_t pb [5];
    if (!(lo_of(v[q[0]], v[q[2]]) < lo_of(v[q[1]], v[q[3]]))) return 1'b0;
    pv = '{v[p[0]], v[p[2]], v[p[3]], v[q[0]], v[q[2]], v[q[3]]};
    pb = '{INTERIOR, c[2], c[3], c[4], c[5]};
    cut_prism(pv, pb);
    pv = '{v[p[0]], v[p[1]], v[p[2]], v[q[0]], v[q[1]], v[q[2]]};
    pb = '{c[0], c[1], INTERIOR, c[4], c[5]};
    cut_prism(pv, pb);
    return 1'b1;
  endfunction

  function automatic void cut_hexa(vid_t v [8], code_t b [6]);
    int m;
    int a [8];
    code_t f [6];
    int p [4], q [4];
    code_t c [6];
    m = 0;
    for (int k = 1; k < 8; k++) if (v[k] < v[m]) m = k;
    a[0] = m;
    if (m >= 4) begin
      a[4] = m - 4;
      for (int k = 1; k < 4; k++) begin
        a[k] = (a[k-1] + 1 > 7) ? 4 : a[k-1] + 1;
        a[4+k] = a[k] - 4;
      end
    end else begin
      a[4] = m + 4;
      for (int k = 1; k < 4; k++) begin
        a[k] = (a[k-1] + 1 > 3) ? 0 : a[k-1] + 1;
        a[4+k] = a[k] + 4;
      end
    end
    for (int k = 0; k < 4; k++) f[k] = b[(m + k) % 4];
    f[4] = (m < 4) ? b[4] : b[5];
    f[5] = (m < 4) ? b[5] : b[4];
    p = '{a[0], a[1], a[2], a[3]}; q = '{a[4], a[5], a[6], a[7]};
    c = '{f[0], f[1], f[2], f[3], f[4], f[5]};
    if (cut_pair(v, p, q, c)) return;
    p = '{a[0], a[1], a[5], a[4]}; q = '{a[3], a[2], a[6], a[7]};
    c = '{f[4], f[1], f[5], f[3], f[0], f[2]};
    if (cut_pair(v, p, q, c)) return;
    p = '{a[0], a[4], a[7], a[3]}; q = '{a[1], a[5], a[6], a[2]};
    c = '{f[0], f[5], f[2], f[4], f[3], f[1]};
    if (cut_pair(v, p, q, c)) return;
    add_tet(v[a[0]], v[a[4]], v[a[5]], v[a[7]], f[5], INTERIOR, f[3], f[0]);
    add_tet(v[a[0]], v[a[2]], v[a[3]], v[a[7]], f[2], f[3], INTERIOR, f[4]);
    add_tet(v[a[0]], v[a[1]], v[a[2]], v[a[5]], f[1], INTERIOR, f[0], f[4]);
    add_tet(v[a[2]], v[a[5]], v[a[6]], v[a[7]], f[5], f[2], INTERIOR, f[1]);
    add_tet(v[a[0]], v[a[2]], v[a[5]], v[a[7]], INTERIOR, INTERIOR, INTERIOR, INTERIOR);
  endfunction

  // Predict the tetrahedra of one element and queue them
  function automatic void predict_split(elem_in_t e);
    code_t b [6];
    vid_t pv [6];
    code_t pb [5];
    for (int k = 0; k < 6; k++) b[k] = e.codes[8*k +: 8];
    tet_buf.delete();
    if (!e.func) begin
      for (int k = 0; k < 6; k++) pv[k] = e.v[k];
      for (int k = 0; k < 5; k++) pb[k] = b[k];
      cut_prism(pv, pb);
      n_prism++;
    end else begin
      cut_hexa(e.v, b);
      if (tet_buf.size() == 6) n_two_prism++; else n_hex5++;
    end
    tet_buf[tet_buf.size()-1].last = 1'b1;
    foreach (tet_buf[i]) expected_tets.push_back(tet_buf[i]);
  endfunction

  function automatic void set_inputs(elem_in_t e);
    in_func <= e.func;
    in_vert0 <= e.v[0]; in_vert1 <= e.v[1]; in_vert2 <= e.v[2]; in_vert3 <= e.v[3];
    in_vert4 <= e.v[4]; in_vert5 <= e.v[5]; in_vert6 <= e.v[6]; in_vert7 <= e.v[7];
    in_face_codes <= e.codes;
  endfunction

  // Driver: present items at the falling edge, advance on transfer
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || xfer_in) begin
        if (pending_elems.size() > 0 && !hold_send &&
            $urandom_range(99) >= send_idle_pct) begin
          set_inputs(pending_elems.pop_front());
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Record transfers at the rising edge for the driver and predictor
  elem_in_t cur_elem;
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    xfer_in <= in_valid && in_ready && rst_n;
    if (rst_n && in_valid && in_ready) begin
      cur_elem.func = in_func;
      cur_elem.v = '{in_vert0, in_vert1, in_vert2, in_vert3,
                     in_vert4, in_vert5, in_vert6, in_vert7};
      cur_elem.codes = in_face_codes;
      predict_split(cur_elem);
      elems_sent++;
    end
  end

  // Monitor: compare each result transfer with the oldest expected tetrahedron
  always @(posedge clk) begin
    tet_out_t x;
    if (rst_n && out_valid && out_ready) begin
      tets_seen++;
      if (expected_tets.size() == 0) begin
        $display("%0t: unexpected tetra %h %h %h %h codes %h last %b", $realtime,
                 out_tet_vert_a, out_tet_vert_b, out_tet_vert_c, out_tet_vert_d,
                 out_tet_face_codes, out_last);
        errors++;
      end else begin
        x = expected_tets.pop_front();
        if (x.a !== out_tet_vert_a || x.b !== out_tet_vert_b || x.c !== out_tet_vert_c ||
            x.d !== out_tet_vert_d || x.fc !== out_tet_face_codes ||
            x.last !== out_last) begin
          $display("%0t: mismatch exp %h %h %h %h codes %h last %b", $realtime,
                   x.a, x.b, x.c, x.d, x.fc, x.last);
          $display("%0t:          got %h %h %h %h codes %h last %b", $realtime,
                   out_tet_vert_a, out_tet_vert_b, out_tet_vert_c, out_tet_vert_d,
                   out_tet_face_codes, out_last);
          errors++;
        end
      end
    end
  end

  // Timeout guard
  always @(posedge clk) begin
    if (cycle_cnt > 400000) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("[hexa_prism_to_tetra_split_unit] ERROR");
      $finish;
    end
  end

  function automatic vid_t rand_vid(int mode);
    case (mode)
      0: return $urandom_range(7);
      1: return 32'hFFFF_FFF8 + $urandom_range(7);
      default: return $urandom;
    endcase
  endfunction

  function automatic elem_in_t rand_elem();
    elem_in_t e;
    int mode;
    mode = $urandom_range(2);
    e.func = 1'($urandom_range(1));
    for (int k = 0; k < 8; k++) e.v[k] = rand_vid(mode);
    e.codes = 48'({$urandom, $urandom});
    if ($urandom_range(3) == 0) e.codes[8*$urandom_range(5) +: 8] = 8'hFF;
    return e;
  endfunction

  function automatic elem_in_t fixed_elem(logic f, vid_t base, int rot, logic [47:0] c);
    elem_in_t e;
    e.func = f;
    for (int k = 0; k < 8; k++) e.v[k] = base + ((k + rot) % 8) * 3 + k;
    e.codes = c;
    return e;
  endfunction

  task automatic drain_all();
    while (pending_elems.size() > 0 || in_valid || expected_tets.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    elem_in_t e;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: rotations of both kinds, extremes, all-equal ids, interior codes
    for (int r = 0; r < 8; r++) begin
      pending_elems.push_back(fixed_elem(1'b0, 32'd100, r, 48'h0605_0403_0201));
      pending_elems.push_back(fixed_elem(1'b1, 32'd100, r, 48'h1615_1413_1211));
    end
    e.func = 1'b0; e.v = '{default: 32'hFFFF_FFFF}; e.codes = '1;
    pending_elems.push_back(e);
    e.func = 1'b1; pending_elems.push_back(e);
    e.v = '{default: 32'h0}; e.codes = '0; pending_elems.push_back(e);
    e.func = 1'b0; pending_elems.push_back(e);
    e.func = 1'b1;
    e.v = '{32'h0, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA,
            32'hFFFF_FFFE, 32'h1, 32'h8000_0000, 32'h7FFF_FFFF};
    e.codes = 48'hAAAA_5555_FF00;
    pending_elems.push_back(e);
    drain_all();

    // Random phases with different idle mixes
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 38 : 81) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 38 : 81) : 0;
      for (int i = 0; i < 47; i++) pending_elems.push_back(rand_elem());
      if (ph == 0) begin
        // hold off until the pipe empties once
        while (pending_elems.size() > 30) @(posedge clk);
        hold_send = 1'b1;
        while (in_valid || expected_tets.size() > 0) @(posedge clk);
        repeat (8) @(posedge clk);
        hold_send = 1'b0;
      end
      drain_all();
    end
    repeat (20) @(posedge clk);

    $display("sent %0d elements: %0d prisms, %0d two-prism hexas, %0d five-tet hexas",
             elems_sent, n_prism, n_two_prism, n_hex5);
    $display("checked %0d tetrahedra under four handshake idle mixes", tets_seen);
    if (errors == 0 && expected_tets.size() == 0) begin
      $display("[hexa_prism_to_tetra_split_unit] OK");
    end else begin
      $display("[hexa_prism_to_tetra_split_unit] ERROR");
    end
    $finish;
  end
endmodule
